@@ hw/rtl/lrc_pkg.sv @@
// Shared types, constants and CRC helper for the line record checker.
`timescale 1ns / 1ps
`default_nettype none
package lrc_pkg;

    typedef logic [5:0] t_pos;
    typedef logic [3:0] t_word;

    localparam t_pos        RECORD_LAST = 6'd39;
    localparam t_pos        CRC_SPAN    = 6'd36;
    localparam t_pos        POS_VERSION = 6'd4;
    localparam t_pos        POS_MODE    = 6'd5;
    localparam t_pos        POS_CHAN    = 6'd6;
    localparam int          NUM_SLOTS   = 9;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  CH_MIN      = 8'd1;
    localparam logic [7:0]  CH_MAX      = 8'd16;
    localparam logic [4:0]  CH_DEFAULT  = 5'd8;

    // configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    typedef struct packed {
        logic               record_ok;
        logic [7:0]         line_mode;
        logic [4:0]         rc_channel;
        logic signed [31:0] start_lat;
        logic signed [31:0] start_lon;
        logic signed [31:0] start_heading;
        logic signed [31:0] finish_lat;
        logic signed [31:0] finish_lon;
        logic signed [31:0] finish_heading;
        logic [31:0]        write_sequence;
    } t_result;

    // reflected CRC-32, one byte; flattens to an xor matrix
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lrc_in_if.sv @@
// Byte input channel of the line record checker.
`timescale 1ns / 1ps
`default_nettype none
interface lrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       first_byte;

    modport source (output valid, output record_byte, output first_byte, input ready);
    modport sink   (input valid, input record_byte, input first_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lrc_out_if.sv @@
// Result channel of the line record checker.
`timescale 1ns / 1ps
`default_nettype none
interface lrc_out_if;
    logic               valid;
    logic               ready;
    logic               record_ok;
    logic [7:0]         line_mode;
    logic [4:0]         rc_channel;
    logic signed [31:0] start_lat;
    logic signed [31:0] start_lon;
    logic signed [31:0] start_heading;
    logic signed [31:0] finish_lat;
    logic signed [31:0] finish_lon;
    logic signed [31:0] finish_heading;
    logic [31:0]        write_sequence;

    modport source (output valid, output record_ok, output line_mode, output rc_channel,
                    output start_lat, output start_lon, output start_heading,
                    output finish_lat, output finish_lon, output finish_heading,
                    output write_sequence, input ready);
    modport sink   (input valid, input record_ok, input line_mode, input rc_channel,
                    input start_lat, input start_lon, input start_heading,
                    input finish_lat, input finish_lon, input finish_heading,
                    input write_sequence, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/line_record_checker_core.sv @@
// Top level of the line record checker.
//
// Usage:
//  - i_in carries one record byte per beat; first_byte=1 restarts the record
//    with that byte as byte 0. After byte 39 the next beat opens a new record.
//  - o_out carries one result beat per 40-byte record: record_ok plus the
//    decoded fields (all zero when the record fails magic, version or CRC).
//  - i_cfg_we/i_cfg_index/i_cfg_data write expected_magic (index 0) and
//    expected_version (index 1); write only while no record is in flight.
// Timing:
//  - One byte per cycle sustained unless a result stall holds i_in.ready low;
//    the byte-wide CRC update and field capture set that rate.
//  - The last byte of a record passes the input register and then the result
//    register before it shows up as a result.
// Reset (synchronous, active low): clears byte position, CRC, header flag,
//  config registers and both pipeline valids. No clearing pass.
// Stall: a result waits in the result register while o_out.ready is low.
//  Bytes keep flowing until the last byte of the next record reaches the
//  input register; then i_in.ready drops until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
module line_record_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrc_in_if.sink      i_in,
    lrc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lrc_pkg::*;

    // configuration
    logic [31:0] r_magic;
    logic [7:0]  r_version;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;

    logic    in_accept, advance, last, out_free;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_magic   <= i_cfg_data;
                CFG_VERSION: r_version <= i_cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // a byte leaves the input register unless it closes a record while the
    // result register is still occupied
    assign advance    = r_in_valid & (~last | out_free);
    assign i_in.ready = ~r_in_valid | advance;
    assign in_accept  = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_in.record_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    lrc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_first   (r_in_first),
        .i_magic   (r_magic),
        .i_version (r_version),
        .o_last    (last),
        .o_result  (result)
    );

    lrc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance & last),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

@@ hw/rtl/lrc_parser.sv @@
// Record parser: byte position, running CRC, field capture and result build.
`timescale 1ns / 1ps
`default_nettype none
module lrc_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic [7:0]      i_byte,
    input  logic            i_first,
    input  logic [31:0]     i_magic,
    input  logic [7:0]      i_version,
    output logic            o_last,
    output lrc_pkg::t_result o_result
);
    import lrc_pkg::*;

    t_pos        r_pos, n_pos, pos_eff;
    logic [31:0] r_crc, n_crc, crc_base, crc_stored;
    logic        r_hdr_ok, n_hdr_ok, hdr_base, rec_ok;
    logic [7:0]  r_mode, r_chan;
    logic [31:0] r_words [NUM_SLOTS];
    t_word       word;
    logic [NUM_SLOTS-1:0] slot_hit;

    always_comb begin
        pos_eff  = i_first ? '0 : r_pos;
        crc_base = i_first ? CRC_INIT : r_crc;
        hdr_base = i_first | r_hdr_ok;
        word     = pos_eff[5:2];
        o_last   = (pos_eff == RECORD_LAST);

        // word 0 -> slot 0, words 2..9 -> slots 1..8
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_hit[k] = (word == ((k == 0) ? 4'd0 : 4'(k + 1)));
        end

        if (o_last) begin
            n_pos    = '0;
            n_crc    = CRC_INIT;
            n_hdr_ok = 1'b1;
        end else begin
            n_pos    = pos_eff + 6'd1;
            n_crc    = (pos_eff < CRC_SPAN) ? crc_byte(crc_base, i_byte) : crc_base;
            n_hdr_ok = hdr_base & ~((pos_eff == POS_VERSION) && (i_byte != i_version));
        end

        // stored CRC completes with the current (last) byte
        crc_stored = {i_byte, r_words[NUM_SLOTS-1][31:8]};
        rec_ok     = hdr_base && (r_words[0] == i_magic) && (crc_stored == ~crc_base);

        o_result = '0;
        if (rec_ok) begin
            o_result.record_ok      = 1'b1;
            o_result.line_mode      = r_mode;
            o_result.rc_channel     = (r_chan >= CH_MIN && r_chan <= CH_MAX) ?
                                      r_chan[4:0] : CH_DEFAULT;
            o_result.start_lat      = r_words[1];
            o_result.start_lon      = r_words[2];
            o_result.start_heading  = r_words[3];
            o_result.finish_lat     = r_words[4];
            o_result.finish_lon     = r_words[5];
            o_result.finish_heading = r_words[6];
            o_result.write_sequence = r_words[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_hdr_ok <= 1'b1;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_hdr_ok <= n_hdr_ok;
        end
    end

    // captured fields, little endian shift-in
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            if (pos_eff == POS_MODE) begin
                r_mode <= i_byte;
            end
            if (pos_eff == POS_CHAN) begin
                r_chan <= i_byte;
            end
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (slot_hit[k]) begin
                    r_words[k] <= {i_byte, r_words[k][31:8]};
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lrc_out_stage.sv @@
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none
module lrc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lrc_pkg::t_result i_result,
    output logic             o_free,
    lrc_out_if.source        o_out
);
    import lrc_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = ~r_valid | o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_data <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.record_ok      = r_data.record_ok;
    assign o_out.line_mode      = r_data.line_mode;
    assign o_out.rc_channel     = r_data.rc_channel;
    assign o_out.start_lat      = r_data.start_lat;
    assign o_out.start_lon      = r_data.start_lon;
    assign o_out.start_heading  = r_data.start_heading;
    assign o_out.finish_lat     = r_data.finish_lat;
    assign o_out.finish_lon     = r_data.finish_lon;
    assign o_out.finish_heading = r_data.finish_heading;
    assign o_out.write_sequence = r_data.write_sequence;

endmodule
`default_nettype wire

@@ hw/rtl/lrc_checker.sv @@
// Port-level assertions for the line record checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lrc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_record_ok,
    input logic [7:0]         i_line_mode,
    input logic [4:0]         i_rc_channel,
    input logic signed [31:0] i_start_lat,
    input logic signed [31:0] i_start_lon,
    input logic signed [31:0] i_start_heading,
    input logic signed [31:0] i_finish_lat,
    input logic signed [31:0] i_finish_lon,
    input logic signed [31:0] i_finish_heading,
    input logic [31:0]        i_write_sequence
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_record_ok) && $stable(i_write_sequence))
        else $error("stalled result beat changed");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_record_ok |-> i_line_mode == '0 && i_rc_channel == '0
            && i_start_lat == '0 && i_start_lon == '0 && i_start_heading == '0
            && i_finish_lat == '0 && i_finish_lon == '0 && i_finish_heading == '0
            && i_write_sequence == '0)
        else $error("failed record carries nonzero fields");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_record_ok |-> i_rc_channel >= 5'd1 && i_rc_channel <= 5'd16)
        else $error("channel out of range");

endmodule

bind line_record_checker_core lrc_checker u_lrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_record_ok      (o_out.record_ok),
    .i_line_mode      (o_out.line_mode),
    .i_rc_channel     (o_out.rc_channel),
    .i_start_lat      (o_out.start_lat),
    .i_start_lon      (o_out.start_lon),
    .i_start_heading  (o_out.start_heading),
    .i_finish_lat     (o_out.finish_lat),
    .i_finish_lon     (o_out.finish_lon),
    .i_finish_heading (o_out.finish_heading),
    .i_write_sequence (o_out.write_sequence)
);
`default_nettype wire
